/* design/sacf_pkg.sv */
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared types, constants and helpers for the set-associative FIFO cache
// tag lookup.
// ----------------------------------------------------------------------------
package sacf_pkg;

    // default geometry
    localparam int ADDR_BITS_DEF  = 8;
    localparam int NUM_SETS_DEF   = 4;
    localparam int NUM_WAYS_DEF   = 2;
    localparam int LINE_WORDS_DEF = 4;

    // fixed widths of the result fields
    localparam int HIT_W       = 1;
    localparam int SET_IDX_W   = 2;
    localparam int TAG_VAL_W   = 4;
    localparam int OUT_TDATA_W = 8;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_sacf_state;

    // controller to datapath commands
    typedef struct packed {
        logic clr_en;     // write one cleared row of the clearing pass
        logic load_addr;  // capture request address and read its set row
        logic commit;     // write back on miss and load the output register
    } t_sacf_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // clearing pass is on its last row
        logic out_busy;   // output register holds a result not yet taken
    } t_sacf_stat;

    // floor of log2, evaluated at elaboration
    function automatic int floor_log2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            r = r + 1;
        end
        return r;
    endfunction

endpackage

/* design/sacf_ctrl.sv */
// ----------------------------------------------------------------------------
// sacf_ctrl
// Controller: sequences the reset clearing pass, request capture and the
// compare / write-back step of each lookup.
// ----------------------------------------------------------------------------
module sacf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  sacf_pkg::t_sacf_stat i_stat,
    output sacf_pkg::t_sacf_cmd  o_cmd
);

    sacf_pkg::t_sacf_state r_state;
    sacf_pkg::t_sacf_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacf_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = sacf_pkg::S_IDLE;
                end
            end
            sacf_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = sacf_pkg::S_LOOK;
                end
            end
            sacf_pkg::S_LOOK: begin
                if (!i_stat.out_busy) begin
                    n_state = sacf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sacf_pkg::S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            sacf_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            sacf_pkg::S_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.load_addr = i_s_tvalid;
            end
            sacf_pkg::S_LOOK: begin
                o_cmd.commit = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* design/sacf_dpath.sv */
// ----------------------------------------------------------------------------
// sacf_dpath
// Datapath: address split, per-set tag / valid row memory, parallel way
// compare, FIFO shift on miss and the registered result.
// ----------------------------------------------------------------------------
module sacf_dpath #(
    parameter int ADDR_BITS  = sacf_pkg::ADDR_BITS_DEF,
    parameter int NUM_SETS   = sacf_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS   = sacf_pkg::NUM_WAYS_DEF,
    parameter int LINE_WORDS = sacf_pkg::LINE_WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sacf_pkg::t_sacf_cmd              i_cmd,
    output sacf_pkg::t_sacf_stat             o_stat,
    input  logic [ADDR_BITS-1:0]             i_addr,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic                             o_hit,
    output logic [sacf_pkg::SET_IDX_W-1:0]   o_set_index,
    output logic [sacf_pkg::TAG_VAL_W-1:0]   o_tag_value
);

    localparam int OB    = sacf_pkg::floor_log2(LINE_WORDS);
    localparam int SB    = sacf_pkg::floor_log2(NUM_SETS);
    localparam int LOW   = OB + SB;
    localparam int TAG_W = (LOW < ADDR_BITS) ? (ADDR_BITS - LOW) : 1;
    localparam int SET_W = (SB > 0) ? SB : 1;
    localparam int ROWS  = 1 << SET_W;
    localparam int EXT_W = ADDR_BITS + LOW + 1;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << SB) - 1);

    // row memory: all ways of one set per row
    logic [NUM_WAYS-1:0][TAG_W-1:0] mem_tag [ROWS];
    logic [NUM_WAYS-1:0]            mem_vld [ROWS];

    logic [NUM_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [NUM_WAYS-1:0]            r_rd_vld;
    logic [SET_W-1:0]               r_set;
    logic [TAG_W-1:0]               r_tag;
    logic [SET_W-1:0]               r_clr_cnt;

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [sacf_pkg::SET_IDX_W-1:0] r_out_set;
    logic [sacf_pkg::TAG_VAL_W-1:0] r_out_tag;

    logic [EXT_W-1:0]               w_ext;
    logic [EXT_W-1:0]               w_set_sh;
    logic [EXT_W-1:0]               w_tag_sh;
    logic [SET_W-1:0]               w_set;
    logic [TAG_W-1:0]               w_tag;
    logic                           w_hit;
    logic                           w_wr_en;
    logic [SET_W-1:0]               w_wr_addr;
    logic [NUM_WAYS-1:0][TAG_W-1:0] w_wr_tag;
    logic [NUM_WAYS-1:0]            w_wr_vld;
    logic [TAG_W+sacf_pkg::TAG_VAL_W-1:0] w_tag_x;
    logic [SET_W+sacf_pkg::SET_IDX_W-1:0] w_set_x;

    // address split into set index and tag
    always_comb begin
        w_ext    = EXT_W'(i_addr);
        w_set_sh = w_ext >> OB;
        w_tag_sh = w_ext >> LOW;
        w_set    = w_set_sh[SET_W-1:0] & SET_MASK;
        w_tag    = w_tag_sh[TAG_W-1:0];
    end

    // parallel compare over the valid ways of the set
    always_comb begin
        w_hit = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_rd_vld[w] && (r_rd_tag[w] == r_tag)) begin
                w_hit = 1'b1;
            end
        end
    end

    // write-back row: cleared row or FIFO shift with new tag in way 0
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_cmd.clr_en) begin
                w_wr_tag[w] = '0;
                w_wr_vld[w] = 1'b0;
            end else if (w == 0) begin
                w_wr_tag[w] = r_tag;
                w_wr_vld[w] = 1'b1;
            end else begin
                w_wr_tag[w] = r_rd_tag[w-1];
                w_wr_vld[w] = r_rd_vld[w-1];
            end
        end
        w_wr_en   = i_cmd.clr_en || (i_cmd.commit && !w_hit);
        w_wr_addr = i_cmd.clr_en ? r_clr_cnt : r_set;
    end

    // row memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_tag[w_wr_addr] <= w_wr_tag;
            mem_vld[w_wr_addr] <= w_wr_vld;
        end
        if (i_cmd.load_addr) begin
            r_rd_tag <= mem_tag[w_set];
            r_rd_vld <= mem_vld[w_set];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_addr) begin
            r_set <= w_set;
            r_tag <= w_tag;
        end
    end

    // clearing pass row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // result fields trimmed to the output widths
    always_comb begin
        w_tag_x = (TAG_W + sacf_pkg::TAG_VAL_W)'(r_tag);
        w_set_x = (SET_W + sacf_pkg::SET_IDX_W)'(r_set);
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit <= w_hit;
            r_out_set <= w_set_x[sacf_pkg::SET_IDX_W-1:0];
            r_out_tag <= w_tag_x[sacf_pkg::TAG_VAL_W-1:0];
        end
    end

    // status
    always_comb begin
        o_stat.clr_last = (r_clr_cnt == SET_W'(ROWS - 1));
        o_stat.out_busy = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_set_index = r_out_set;
    assign o_tag_value = r_out_tag;

endmodule

/* design/set_assoc_cache_fifo_lookup.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup: tag lookup with FIFO replacement
// A request is captured and its set row read into registers; the compare,
// the write-back on a miss and the load of the output register follow, held
// while the output register holds a result not yet taken. No new request is
// taken before that commit. Reset: a clearing pass of 2**floor(log2(NUM_SETS))
// rows (at least 2) runs with s_tready low.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup #(
    parameter int ADDR_BITS  = sacf_pkg::ADDR_BITS_DEF,
    parameter int NUM_SETS   = sacf_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS   = sacf_pkg::NUM_WAYS_DEF,
    parameter int LINE_WORDS = sacf_pkg::LINE_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]  s_tdata,   // address
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sacf_pkg::OUT_TDATA_W-1:0] m_tdata,  // set_index, tag_value
    output logic                            m_tuser    // hit
);

    sacf_pkg::t_sacf_cmd  w_cmd;
    sacf_pkg::t_sacf_stat w_stat;
    logic [sacf_pkg::SET_IDX_W-1:0] w_set_index;
    logic [sacf_pkg::TAG_VAL_W-1:0] w_tag_value;

    // controller
    sacf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    sacf_dpath #(
        .ADDR_BITS  (ADDR_BITS),
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LINE_WORDS (LINE_WORDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_addr      (s_tdata[ADDR_BITS-1:0]),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_hit       (m_tuser),
        .o_set_index (w_set_index),
        .o_tag_value (w_tag_value)
    );

    // result packing, set_index in the low bits
    assign m_tdata = sacf_pkg::OUT_TDATA_W'({w_tag_value, w_set_index});

`ifndef SYNTHESIS
    // a result is only committed into a free output register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("commit while output register is stalled");

    // output valid only rises after a commit
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(w_cmd.commit))
        else $error("result valid without commit");

    // an accepted request blocks the next one until its lookup is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a lookup is in flight");

    // at most one datapath command at once: clearing pass, request capture or commit
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.clr_en, w_cmd.load_addr, w_cmd.commit}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for set_assoc_cache_fifo_lookup
// Drives address requests, predicts hit/miss per set with a FIFO-ordered
// tag table of its own, and checks every result in order. Random stalls
// on both sides plus one long output hold-off exercise the back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    // geometry of the block under test
    localparam int ADDR_W   = sacf_pkg::ADDR_BITS_DEF;
    localparam int SETS     = sacf_pkg::NUM_SETS_DEF;
    localparam int WAYS     = sacf_pkg::NUM_WAYS_DEF;
    localparam int OFS_W    = sacf_pkg::floor_log2(sacf_pkg::LINE_WORDS_DEF);
    localparam int SEL_W    = sacf_pkg::floor_log2(sacf_pkg::NUM_SETS_DEF);
    localparam int TAG_W    = ADDR_W - OFS_W - SEL_W;
    localparam int IN_W     = ((ADDR_W + 7) / 8) * 8;
    localparam int SET_IDX_W   = sacf_pkg::SET_IDX_W;
    localparam int TAG_VAL_W   = sacf_pkg::TAG_VAL_W;
    localparam int OUT_TDATA_W = sacf_pkg::OUT_TDATA_W;
    localparam int TAIL     = 150;
    localparam int WDOG_MAX = 2000;
    localparam int HOLD_AT  = 500;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic                 hit;
        logic [SET_IDX_W-1:0] set_idx;
        logic [TAG_VAL_W-1:0] tag_val;
    } t_lookup_res;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                gap;
    } t_addr_req;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // address
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;    // set_index, tag_value
    logic              m_tuser;         // hit

    // predicted cache contents, way 0 is the newest
    logic [TAG_W-1:0]  tag_tbl   [SETS][WAYS];
    logic              valid_tbl [SETS][WAYS];

    t_addr_req   addr_q [$];
    t_lookup_res lookup_q [$];
    t_addr_req   drv_req;

    int n_items;
    int n_sent;
    int n_rcvd;
    int n_hits;
    int fail_cnt;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;
    int idle_cycles;

    set_assoc_cache_fifo_lookup dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tag lookup with FIFO replacement on miss, queues the expected result
    task automatic lookup_and_fill(input logic [ADDR_W-1:0] addr);
        logic [SEL_W-1:0] sel;
        logic [TAG_W-1:0] tag;
        t_lookup_res      res;
        logic             hit;
        sel = addr[OFS_W +: SEL_W];
        tag = addr[ADDR_W-1 -: TAG_W];
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (valid_tbl[sel][w] && tag_tbl[sel][w] == tag) begin
                hit = 1'b1;
            end
        end
        if (!hit) begin
            for (int w = WAYS - 1; w > 0; w--) begin
                tag_tbl[sel][w]   = tag_tbl[sel][w-1];
                valid_tbl[sel][w] = valid_tbl[sel][w-1];
            end
            tag_tbl[sel][0]   = tag;
            valid_tbl[sel][0] = 1'b1;
        end
        res.hit     = hit;
        res.set_idx = SET_IDX_W'(sel);
        res.tag_val = TAG_VAL_W'(tag);
        lookup_q.push_back(res);
    endtask

    // compare one taken result against the oldest prediction
    task automatic check_lookup();
        t_lookup_res exp_res;
        if (lookup_q.size() == 0) begin
            $error("result with nothing expected: hit %0b tdata %0h", m_tuser, m_tdata);
            fail_cnt++;
        end else begin
            exp_res = lookup_q.pop_front();
            if (m_tuser !== exp_res.hit) begin
                $error("hit: expected %0h, got %0h", exp_res.hit, m_tuser);
                fail_cnt++;
            end
            if (m_tdata[SET_IDX_W-1:0] !== exp_res.set_idx) begin
                $error("set_index: expected %0h, got %0h", exp_res.set_idx,
                       m_tdata[SET_IDX_W-1:0]);
                fail_cnt++;
            end
            if (m_tdata[SET_IDX_W +: TAG_VAL_W] !== exp_res.tag_val) begin
                $error("tag_value: expected %0h, got %0h", exp_res.tag_val,
                       m_tdata[SET_IDX_W +: TAG_VAL_W]);
                fail_cnt++;
            end
            if (m_tdata[OUT_TDATA_W-1:SET_IDX_W+TAG_VAL_W] !== '0) begin
                $error("tdata padding: expected %0h, got %0h", 0,
                       m_tdata[OUT_TDATA_W-1:SET_IDX_W+TAG_VAL_W]);
                fail_cnt++;
            end
            if (exp_res.hit) begin
                n_hits++;
            end
        end
        n_rcvd++;
    endtask

    // request driver: offers the queued addresses, honoring their gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                lookup_and_fill(s_tdata[ADDR_W-1:0]);
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (addr_q.size() > 0 && addr_q[0].gap > 0) begin
                    gap_left = addr_q[0].gap - 1;
                    addr_q[0].gap = 0;
                    s_tvalid <= 1'b0;
                end else if (addr_q.size() > 0) begin
                    drv_req = addr_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'(drv_req.addr);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks taken results and drives m_tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_lookup();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && n_rcvd >= HOLD_AT) begin
                // long hold-off so the block fills up and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (n_rcvd < n_items - TAIL && (n_rcvd / 128) % 3 != 2 &&
                         $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("** set_assoc_cache_fifo_lookup: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [ADDR_W-1:0] directed [$];
        t_addr_req         req;
        logic [TAG_W-1:0]  tag_base;
        int                n_rand;
        int                idx;

        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                valid_tbl[s][w] = 1'b0;
            end
        end

        // fill, hit, eviction order and address extremes
        directed = '{8'h00, 8'h03, 8'hFF, 8'hFC, 8'h10, 8'h01, 8'h20, 8'h00,
                     8'h13, 8'h0C, 8'hF4, 8'h08, 8'h8B, 8'h09, 8'h88, 8'h55,
                     8'hAA, 8'h0A, 8'h8A, 8'h7F, 8'h80};
        n_rand  = 1850;
        n_items = directed.size() + n_rand;
        idx     = 0;
        foreach (directed[i]) begin
            req.addr = directed[i];
            req.gap  = 0;
            addr_q.push_back(req);
            idx++;
        end

        // mostly a narrow tag pool per stretch to get hits and evictions
        tag_base = '0;
        for (int i = 0; i < n_rand; i++) begin
            if (i % 64 == 0) begin
                tag_base = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
            end
            if ($urandom_range(0, 3) != 0) begin
                req.addr = {tag_base ^ TAG_W'($urandom_range(0, 2)),
                            SEL_W'($urandom_range(0, SETS - 1)),
                            OFS_W'($urandom_range(0, (1 << OFS_W) - 1))};
            end else begin
                req.addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            end
            if (idx < n_items - TAIL && (idx / 96) % 3 != 1 &&
                $urandom_range(0, 5) == 0) begin
                req.gap = $urandom_range(1, 16);
            end else begin
                req.gap = 0;
            end
            addr_q.push_back(req);
            idx++;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (addr_q.size() != 0 || s_tvalid || lookup_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (lookup_q.size() != 0) begin
            $error("%0d expected results never arrived", lookup_q.size());
            fail_cnt++;
        end
        $display("run covered %0d lookups (%0d hits, %0d misses) with random stalls",
                 n_sent, n_hits, n_rcvd - n_hits);
        $display("and a %0d-cycle output hold-off", HOLD_LEN);
        if (fail_cnt == 0) begin
            $display("** set_assoc_cache_fifo_lookup: PASSED **");
        end else begin
            $display("** set_assoc_cache_fifo_lookup: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/sacf_pkg.sv
design/sacf_ctrl.sv
design/sacf_dpath.sv
design/set_assoc_cache_fifo_lookup.sv
bench/tb_top.sv
